// ===== rtl/core/ffc_pkg.sv =====
// Shared types, constants and helpers of the flat-field coefficient calculator.
`timescale 1ns / 1ps

package ffc_pkg;

  localparam int unsigned MAX_COLUMNS_DEF    = 1024;
  localparam int unsigned MAX_ROWS_DEF       = 512;
  localparam int unsigned GAIN_FRAC_BITS_DEF = 16;

  localparam int unsigned PIXEL_W   = 8;
  localparam int unsigned COL_OUT_W = 10;
  localparam int unsigned SUM_W     = 17;
  localparam int unsigned SUM_EXT_W = SUM_W + 1;
  localparam int unsigned GAIN_W    = 24;
  localparam int unsigned BAND_W    = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};
  localparam logic [BAND_W-1:0] BAND_MAX = 10'd512;
  localparam logic [PIXEL_W-1:0] DARK_MAX = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DARK_FIRST_ROW = 3'd0,
    CFG_DARK_ROW_COUNT = 3'd1,
    CFG_WHITE_ROW      = 3'd2,
    CFG_GAIN_TARGET    = 3'd3,
    CFG_COLUMNS_IN_USE = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [8:0]  dark_first_row;
    logic [9:0]  dark_row_count;
    logic [8:0]  white_row;
    logic [7:0]  gain_target;
    logic [10:0] columns_in_use;
  } cfg_t;

  typedef struct packed {
    logic [COL_OUT_W-1:0] column;
    logic [SUM_W-1:0]     sum;
    logic [PIXEL_W-1:0]   pixel;
    logic                 last;
  } entry_t;

  typedef struct packed {
    logic [COL_OUT_W-1:0] column;
    logic [PIXEL_W-1:0]   dark_level;
    logic [GAIN_W-1:0]    gain;
    logic                 gain_invalid;
    logic                 last;
  } result_t;

  function automatic logic [BAND_W-1:0] band_rows(input logic [BAND_W-1:0] n);
    logic [BAND_W-1:0] r;
    r = n;
    if (n == '0) begin
      r = 10'd1;
    end else if (n > BAND_MAX) begin
      r = BAND_MAX;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/flat_field_coefficient_calc_top.sv =====
// Top level of the flat-field coefficient calculator with its configuration registers.
//
//   Channel   Direction  Handshake              Payload
//   in        input      in_valid_i/in_ready_o   pixel_i, frame_start_i
//   out       output     out_valid_o/out_ready_i column_o, dark_level_o, gain_o,
//                                                gain_invalid_o, last_o
//   cfg       input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// Pixels outside the white row are taken one per cycle; the per-column dark sum is a
// read-modify-write via separate read and write ports, with a bypass for back-to-back hits.
// A white row pixel takes a dark level division and, if above it, a gain division in the
// shared serial divider, DIV_W being the wider of 17 and 8 + GAIN_FRAC_BITS.
// The front end stalls only when a white row word finds the four-word queue full.
// Reset clears counters and control state; the dark sum memory is not cleared.
`timescale 1ns / 1ps

module flat_field_coefficient_calc_top #(
  parameter int unsigned MAX_COLUMNS    = ffc_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS       = ffc_pkg::MAX_ROWS_DEF,
  parameter int unsigned GAIN_FRAC_BITS = ffc_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ffc_pkg::PIXEL_W-1:0]       pixel_i,
  input  logic                              frame_start_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ffc_pkg::COL_OUT_W-1:0]     column_o,
  output logic [ffc_pkg::PIXEL_W-1:0]       dark_level_o,
  output logic [ffc_pkg::GAIN_W-1:0]        gain_o,
  output logic                              gain_invalid_o,
  output logic                              last_o,
  input  logic                              cfg_we_i,
  input  logic [ffc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ffc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  ffc_pkg::cfg_t    cfg_q;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  ffc_pkg::entry_t  q_in;
  ffc_pkg::entry_t  q_out;
  ffc_pkg::result_t result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dark_first_row <= 9'd100;
      cfg_q.dark_row_count <= 10'd100;
      cfg_q.white_row      <= 9'd400;
      cfg_q.gain_target    <= 8'd240;
      cfg_q.columns_in_use <= 11'd648;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ffc_pkg::CFG_DARK_FIRST_ROW: cfg_q.dark_first_row <= cfg_data_i[8:0];
        ffc_pkg::CFG_DARK_ROW_COUNT: cfg_q.dark_row_count <= cfg_data_i[9:0];
        ffc_pkg::CFG_WHITE_ROW:      cfg_q.white_row      <= cfg_data_i[8:0];
        ffc_pkg::CFG_GAIN_TARGET:    cfg_q.gain_target    <= cfg_data_i[7:0];
        ffc_pkg::CFG_COLUMNS_IN_USE: cfg_q.columns_in_use <= cfg_data_i[10:0];
        default: begin
        end
      endcase
    end
  end

  ffc_front #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_i      (pixel_i),
    .frame_start_i(frame_start_i),
    .push_o       (q_push),
    .entry_o      (q_in),
    .full_i       (q_full)
  );

  ffc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .entry_o(q_out),
    .empty_o(q_empty)
  );

  ffc_back #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .empty_i    (q_empty),
    .entry_i    (q_out),
    .pop_o      (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .result_o   (result)
  );

  assign column_o       = result.column;
  assign dark_level_o   = result.dark_level;
  assign gain_o         = result.gain;
  assign gain_invalid_o = result.gain_invalid;
  assign last_o         = result.last;

endmodule

// ===== rtl/core/ffc_front.sv =====
// Front end: raster counters, per-column dark sum memory and white row classification.
`timescale 1ns / 1ps

module ffc_front #(
  parameter int unsigned MAX_COLUMNS = ffc_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = ffc_pkg::MAX_ROWS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ffc_pkg::cfg_t                cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ffc_pkg::PIXEL_W-1:0]  pixel_i,
  input  logic                         frame_start_i,
  output logic                         push_o,
  output ffc_pkg::entry_t              entry_o,
  input  logic                         full_i
);

  localparam int unsigned CW   = $clog2(MAX_COLUMNS);
  localparam int unsigned RW   = $clog2(MAX_ROWS);
  localparam int unsigned RW1  = RW + 1;
  localparam int unsigned CNW  = (CW + 1 > 11) ? CW + 1 : 11;
  localparam int unsigned BW   = ((RW > 10) ? RW : 10) + 1;
  localparam int unsigned SW   = ffc_pkg::SUM_W;
  localparam int unsigned SXW  = ffc_pkg::SUM_EXT_W;

  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;

  logic [RW-1:0]  r_cur;
  logic [CW-1:0]  c_cur;
  logic [CNW-1:0] cols;
  logic [CNW-1:0] c_inc;
  logic           is_last;
  logic [RW:0]    r_inc;
  logic           row_wrap;
  logic [BW-1:0]  r_b;
  logic [BW-1:0]  first_b;
  logic [BW-1:0]  rows_b;
  logic [BW-1:0]  white_b;
  logic           in_band;
  logic           accept;

  logic [SW-1:0] mem [MAX_COLUMNS];
  logic [SW-1:0] rd_q;

  logic                           b_valid_q;
  logic [CW-1:0]                  b_col_q;
  logic [ffc_pkg::PIXEL_W-1:0]    b_px_q;
  logic                           b_band_q;
  logic                           b_first_q;
  logic                           b_white_q;
  logic                           b_last_q;
  logic                           hit_q;
  logic [SW-1:0]                  byp_q;

  logic [SW-1:0]  old_sum;
  logic [SXW-1:0] sum_add;
  logic [SW-1:0]  sum_sat;
  logic [SW-1:0]  sum_new;
  logic           b_leave;
  logic           wr_en;
  logic [31:0]    col_ext;

  assign r_cur = frame_start_i ? '0 : row_q;
  assign c_cur = frame_start_i ? '0 : col_q;

  always_comb begin
    cols = CNW'(cfg_i.columns_in_use);
    if (cols == '0) begin
      cols = CNW'(1);
    end else if (cols > CNW'(MAX_COLUMNS)) begin
      cols = CNW'(MAX_COLUMNS);
    end
  end

  assign c_inc    = CNW'(c_cur) + CNW'(1);
  assign is_last  = (c_inc >= cols);
  assign r_inc    = {1'b0, r_cur} + RW1'(1);
  assign row_wrap = (r_inc >= RW1'(MAX_ROWS));

  assign r_b     = BW'(r_cur);
  assign first_b = BW'(cfg_i.dark_first_row);
  assign rows_b  = BW'(ffc_pkg::band_rows(cfg_i.dark_row_count));
  assign white_b = BW'(cfg_i.white_row);
  assign in_band = (r_b >= first_b) && ((r_b - first_b) < rows_b);

  assign old_sum = hit_q ? byp_q : rd_q;
  assign sum_add = {1'b0, old_sum} + SXW'(b_px_q);
  assign sum_sat = sum_add[SW] ? ffc_pkg::SUM_MAX : sum_add[SW-1:0];
  assign sum_new = b_first_q ? SW'(b_px_q) : sum_sat;

  assign b_leave    = b_valid_q && (!b_white_q || !full_i);
  assign in_ready_o = !b_valid_q || b_leave;
  assign accept     = in_valid_i && in_ready_o;
  assign wr_en      = b_leave && b_band_q;

  assign col_ext        = 32'(b_col_q);
  assign push_o         = b_leave && b_white_q;
  assign entry_o.column = col_ext[ffc_pkg::COL_OUT_W-1:0];
  assign entry_o.sum    = b_band_q ? sum_new : old_sum;
  assign entry_o.pixel  = b_px_q;
  assign entry_o.last   = b_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      b_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= is_last ? '0 : c_inc[CW-1:0];
        row_q <= is_last ? (row_wrap ? '0 : r_inc[RW-1:0]) : r_cur;
        b_valid_q <= 1'b1;
      end else if (b_leave) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_col_q   <= c_cur;
      b_px_q    <= pixel_i;
      b_band_q  <= in_band;
      b_first_q <= (r_b == first_b);
      b_white_q <= (r_b == white_b);
      b_last_q  <= is_last;
      hit_q     <= wr_en && (b_col_q == c_cur);
      byp_q     <= sum_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[b_col_q] <= sum_new;
    end
    if (accept) begin
      rd_q <= mem[c_cur];
    end
  end

endmodule

// ===== rtl/core/ffc_queue.sv =====
// Short queue of white row words between the front end and the back end.
`timescale 1ns / 1ps

module ffc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ffc_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output ffc_pkg::entry_t entry_o,
  output logic            empty_o
);

  localparam int unsigned DEPTH = ffc_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned NW    = $clog2(DEPTH + 1);

  ffc_pkg::entry_t slot_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q;
  logic [PW-1:0]   rd_ptr_q;
  logic [NW-1:0]   count_q;

  assign full_o  = (count_q == NW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign entry_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + NW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("Word pushed into a full queue.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && empty_o))
    else $error("Word popped from an empty queue.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + NW'(1)))
    else $error("Queue fill count did not follow a push.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= NW'(DEPTH))
    else $error("Queue fill count beyond its depth.");
`endif

endmodule

// ===== rtl/core/ffc_div.sv =====
// Radix-2 restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module ffc_div #(
  parameter int unsigned DW = 24,
  parameter int unsigned VW = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned CNTW = $clog2(DW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CNTW-1:0] cnt_q;
  logic [DW-1:0]   quo_q;
  logic [VW-1:0]   rem_q;
  logic [VW-1:0]   dvs_q;

  logic [VW:0] trial;
  logic [VW:0] diff;
  logic        ge;

  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
    end
  end

endmodule

// ===== rtl/core/ffc_back.sv =====
// Back end: dark level and gain division sequencer with the result register.
`timescale 1ns / 1ps

module ffc_back #(
  parameter int unsigned GAIN_FRAC_BITS = ffc_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ffc_pkg::cfg_t    cfg_i,
  input  logic             empty_i,
  input  ffc_pkg::entry_t  entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ffc_pkg::result_t result_o
);

  localparam int unsigned GDW   = ffc_pkg::PIXEL_W + GAIN_FRAC_BITS;
  localparam int unsigned DIV_W = (GDW > ffc_pkg::SUM_W) ? GDW : ffc_pkg::SUM_W;
  localparam int unsigned VW    = ffc_pkg::BAND_W;
  localparam int unsigned PW    = ffc_pkg::PIXEL_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DARK = 4'b0010,
    ST_GAIN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [PW-1:0]                  px_q;
  logic [ffc_pkg::COL_OUT_W-1:0]  col_q;
  logic                           last_q;
  logic [PW-1:0]                  dark_q, dark_d;
  logic [ffc_pkg::GAIN_W-1:0]     gain_q, gain_d;
  logic                           bad_q, bad_d;
  logic                           out_valid_q;
  ffc_pkg::result_t               result_q;

  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [VW-1:0]    div_divisor;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;
  logic [31:0]      quo32;
  logic [PW-1:0]    dark_now;
  logic             emit;

  ffc_div #(
    .DW(DIV_W),
    .VW(VW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  assign quo32    = 32'(div_quo);
  assign dark_now = (quo32 > 32'(ffc_pkg::DARK_MAX)) ? ffc_pkg::DARK_MAX : quo32[PW-1:0];
  assign emit     = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    dark_d       = dark_q;
    gain_d       = gain_q;
    bad_d        = bad_q;
    pop_o        = 1'b0;
    div_start    = 1'b0;
    div_dividend = DIV_W'(entry_i.sum);
    div_divisor  = ffc_pkg::band_rows(cfg_i.dark_row_count);
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o     = 1'b1;
          div_start = 1'b1;
          state_d   = ST_DARK;
        end
      end
      ST_DARK: begin
        div_dividend = DIV_W'(cfg_i.gain_target) << GAIN_FRAC_BITS;
        div_divisor  = VW'(px_q - dark_now);
        if (div_done) begin
          dark_d = dark_now;
          if (px_q > dark_now) begin
            div_start = 1'b1;
            bad_d     = 1'b0;
            state_d   = ST_GAIN;
          end else begin
            gain_d  = ffc_pkg::GAIN_MAX;
            bad_d   = 1'b1;
            state_d = ST_EMIT;
          end
        end
      end
      ST_GAIN: begin
        if (div_done) begin
          gain_d  = (quo32 > 32'(ffc_pkg::GAIN_MAX)) ? ffc_pkg::GAIN_MAX
                                                      : quo32[ffc_pkg::GAIN_W-1:0];
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dark_q <= dark_d;
    gain_q <= gain_d;
    bad_q  <= bad_d;
    if (pop_o) begin
      px_q   <= entry_i.pixel;
      col_q  <= entry_i.column;
      last_q <= entry_i.last;
    end
    if (emit) begin
      result_q.column       <= col_q;
      result_q.dark_level   <= dark_q;
      result_q.gain         <= gain_q;
      result_q.gain_invalid <= bad_q;
      result_q.last         <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule
